// ===== rtl/skl_pkg.sv =====
// Shared types and constants for the seed-to-key LFSR block.
`timescale 1ns / 1ps

package skl_pkg;

    localparam int KEY_W = 32;
    localparam int CNT_W = 7;
    localparam int BYTE_W = 8;

    localparam logic [KEY_W-1:0] SEC_RESET = 32'h594E_348A;
    localparam logic [BYTE_W-1:0] SB2_MASK = 8'hA5;
    localparam logic [BYTE_W-1:0] SB3_MASK = 8'h5A;

    localparam int TAP_A = 30;
    localparam int TAP_B = 24;
    localparam int TAP_C = 12;
    localparam int TAP_D = 2;

    localparam logic [1:0] SEL_B3 = 2'd0;
    localparam logic [1:0] SEL_B2 = 2'd1;
    localparam logic [1:0] SEL_B1 = 2'd2;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SHIFT
    } t_state;

    typedef struct packed {
        logic load;
        logic shift;
    } t_ctrl;

endpackage

// ===== rtl/skl_cell.sv =====
// One bit of the LFSR chain: load a seed bit or take the neighbor's bit.
`timescale 1ns / 1ps

module skl_cell
(
    input  logic i_clk,
    input  logic i_load,
    input  logic i_shift,
    input  logic i_seed_bit,
    input  logic i_prev,
    output logic o_bit
);

    logic r_bit;
    logic n_bit;

    always_comb begin
        n_bit = r_bit;
        if (i_load) begin
            n_bit = i_seed_bit;
        end else if (i_shift) begin
            n_bit = i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit <= n_bit;
    end

    assign o_bit = r_bit;

endmodule

// ===== rtl/skl_ctrl.sv =====
// Shift count computation, shift counter and sequencing for the LFSR chain.
`timescale 1ns / 1ps

module skl_ctrl
    import skl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [KEY_W-1:0] i_seed,
    input  logic [KEY_W-1:0] i_const,
    input  logic             i_out_free,
    output logic             o_in_stall,
    output t_ctrl            o_ctrl,
    output logic             o_done
);

    t_state r_state;
    t_state n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [BYTE_W-1:0] pick;
    logic [BYTE_W-1:0] sb1;
    logic [BYTE_W-1:0] sb2;
    logic [BYTE_W-1:0] sb3;
    logic [BYTE_W-1:0] cnt_raw;
    logic [1:0] sel;
    logic cnt_zero;

    assign sel = {i_const[11], i_const[21]};
    assign sb1 = i_const[9:2];
    assign sb2 = i_const[30:23] ^ SB2_MASK;
    assign sb3 = i_const[20:13] ^ SB3_MASK;
    assign cnt_zero = (r_cnt == '0);

    always_comb begin
        case (sel)
            SEL_B3:  pick = i_seed[31:24];
            SEL_B2:  pick = i_seed[23:16];
            SEL_B1:  pick = i_seed[15:8];
            default: pick = i_seed[7:0];
        endcase
        cnt_raw = ((pick ^ sb1) & sb2) + sb3;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (cnt_zero && i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall   = 1'b1;
        o_ctrl.load  = 1'b0;
        o_ctrl.shift = 1'b0;
        o_done       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall  = 1'b0;
                o_ctrl.load = i_in_valid;
            end
            ST_SHIFT: begin
                o_ctrl.shift = !cnt_zero;
                o_done       = cnt_zero && i_out_free;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    // negative signed count means no shifts
    always_comb begin
        n_cnt = r_cnt;
        if (o_ctrl.load) begin
            n_cnt = cnt_raw[BYTE_W-1] ? '0 : cnt_raw[CNT_W-1:0];
        end else if (o_ctrl.shift) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== rtl/seed_to_key_lfsr.sv =====
// Top level of the seed-to-key block: config register, LFSR cell chain, output stage.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel i_in_valid / o_in_stall carries a 32-bit seed (first byte in
//   bits 31..24). Output channel o_out_valid / i_out_stall carries the 32-bit key.
//   A transfer happens at a clock edge with valid high and stall low.
//   i_cfg_we / i_cfg_data write the secret constant; write only while idle.
// Operation:
//   The constant and one seed byte set a shift count n of 0..127. After the input
//   transfer the chain of 32 one-bit cells shifts once per cycle, n times in all; once
//   the count is spent and the output register is free, the key moves into the output
//   register. The input stays stalled until then, so the next seed is taken only after
//   the previous key is written, as the single shift counter serves one seed at a time.
// Stall:
//   A key waiting in the output register does not block a new seed; the chain
//   holds its finished value until the output register is free.
// Reset:
//   i_rst_n low at a clock edge empties the block and restores the constant
//   to 0x594E348A.
//

module seed_to_key_lfsr
    import skl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [KEY_W-1:0] i_seed,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [KEY_W-1:0] o_key,
    input  logic             i_cfg_we,
    input  logic [KEY_W-1:0] i_cfg_data
);

    logic [KEY_W-1:0] r_const;
    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] n_key;
    logic r_out_valid;
    logic n_out_valid;
    logic [KEY_W-1:0] s_bits;
    logic [KEY_W-1:0] s_prev;
    logic [KEY_W-1:0] s_mixed;
    logic s_fb;
    logic s_out_free;
    logic s_done;
    t_ctrl s_ctrl;

    assign s_out_free = !r_out_valid || !i_out_stall;

    skl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_seed     (i_seed),
        .i_const    (r_const),
        .i_out_free (s_out_free),
        .o_in_stall (o_in_stall),
        .o_ctrl     (s_ctrl),
        .o_done     (s_done)
    );

    assign s_fb = s_bits[TAP_A] ^ s_bits[TAP_B] ^ s_bits[TAP_C] ^ s_bits[TAP_D];
    assign s_prev = {s_bits[KEY_W-2:0], s_fb};

    for (genvar g = 0; g < KEY_W; g++) begin : g_cell
        skl_cell u_cell (
            .i_clk      (i_clk),
            .i_load     (s_ctrl.load),
            .i_shift    (s_ctrl.shift),
            .i_seed_bit (i_seed[g]),
            .i_prev     (s_prev[g]),
            .o_bit      (s_bits[g])
        );
    end

    always_comb begin
        if (r_const[0]) begin
            s_mixed = {s_bits[15:8], s_bits[31:24], s_bits[7:0], s_bits[23:16]};
        end else begin
            s_mixed = s_bits;
        end
        n_key = r_key;
        n_out_valid = r_out_valid && i_out_stall;
        if (s_done) begin
            n_key = s_mixed ^ r_const;
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_const     <= SEC_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_const <= i_cfg_data;
            end
            r_out_valid <= n_out_valid;
        end
        r_key <= n_key;
    end

    assign o_out_valid = r_out_valid;
    assign o_key = r_key;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a seed transfer");

    a_no_done_while_shifting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_ctrl.shift && s_done))
        else $error("key written while chain still shifting");

    a_done_gives_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_done |=> o_out_valid)
        else $error("finished key did not reach the output");

    a_done_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_done |-> (!o_out_valid || !i_out_stall))
        else $error("pending key overwritten");

endmodule
